// ===== design/u2u_pkg.sv =====
`default_nettype none

package u2u_pkg;

	// Longest sequence held before it completes: lead plus four continuations
	localparam int unsigned HELD_MAX = 5;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam logic [15:0] REPL_CHAR = 16'h003F;

	typedef enum logic [1:0] {
		KIND_DECODED = 2'd0,
		KIND_RAW     = 2'd1,
		KIND_REPL    = 2'd2
	} u2u_kind_t;

	typedef logic [HELD_MAX-1:0][7:0] u2u_held_t;

	// One queued work item: flush the first flush_n held bytes raw,
	// then optionally give one final unit.
	typedef struct packed {
		u2u_held_t   held;
		logic [2:0]  flush_n;
		logic        has_fin;
		logic [15:0] fin_unit;
		u2u_kind_t   fin_kind;
		logic        last;
	} u2u_cmd_t;

	function automatic logic [2:0] lead_length(input logic [7:0] b);
		logic [2:0] len;
		len = 3'd0;
		if (b inside {[8'hC0:8'hDF]}) len = 3'd2;
		else if (b inside {[8'hE0:8'hEF]}) len = 3'd3;
		else if (b inside {[8'hF0:8'hF7]}) len = 3'd4;
		else if (b inside {[8'hF8:8'hFB]}) len = 3'd5;
		else if (b inside {[8'hFC:8'hFD]}) len = 3'd6;
		return len;
	endfunction

	function automatic logic [7:0] lead_mask(input logic [2:0] len);
		logic [7:0] m;
		case (len)
			3'd2:    m = 8'h1F;
			3'd3:    m = 8'h0F;
			3'd4:    m = 8'h07;
			default: m = 8'h03;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== design/u2u_ifs.sv =====
`default_nettype none

interface u2u_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       string_last;

	modport source (output valid, in_byte, string_last, input ready);
	modport sink (input valid, in_byte, string_last, output ready);
endinterface

interface u2u_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic [1:0]  unit_kind;
	logic        run_last;
	logic        string_end;

	modport source (output valid, code_unit, unit_kind, run_last, string_end, input ready);
	modport sink (input valid, code_unit, unit_kind, run_last, string_end, output ready);
endinterface

`default_nettype wire

// ===== design/u2u_front.sv =====
`default_nettype none

module u2u_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	u2u_byte_if.sink            utf8,
	input  wire logic           full,
	output u2u_pkg::u2u_cmd_t   cmd,
	output logic                push
);

	u2u_pkg::u2u_held_t held_q;
	logic [2:0]  cnt_q, cnt_d;
	logic [2:0]  exp_q, exp_d;
	logic [15:0] acc_q, acc_d;
	logic        ovf_q, ovf_d;
	logic        hold_wr;
	logic [2:0]  hold_idx;
	logic        accept;
	logic [7:0]  b;
	logic        is_cont;
	logic        fresh;
	logic [2:0]  len;
	logic [15:0] nv16;
	logic        novf;

	assign utf8.ready = !full;
	assign accept = utf8.valid && utf8.ready;
	assign b = utf8.in_byte;
	assign is_cont = (b[7:6] == 2'b10);
	assign len = u2u_pkg::lead_length(b);
	assign nv16 = {acc_q[9:0], b[5:0]};
	assign novf = ovf_q || (acc_q[15:10] != 6'd0);

	always_comb begin
		cnt_d = cnt_q;
		exp_d = exp_q;
		acc_d = acc_q;
		ovf_d = ovf_q;
		hold_wr = 1'b0;
		hold_idx = cnt_q;
		fresh = 1'b1;
		cmd.held = held_q;
		cmd.flush_n = 3'd0;
		cmd.has_fin = 1'b0;
		cmd.fin_unit = {8'h00, b};
		cmd.fin_kind = u2u_pkg::KIND_RAW;
		cmd.last = utf8.string_last;

		if (cnt_q != 3'd0) begin
			if (is_cont) begin
				fresh = 1'b0;
				if (cnt_q + 3'd1 == exp_q) begin
					// sequence complete: give value or replacement
					cmd.has_fin = 1'b1;
					if (novf) begin
						cmd.fin_unit = u2u_pkg::REPL_CHAR;
						cmd.fin_kind = u2u_pkg::KIND_REPL;
					end else begin
						cmd.fin_unit = nv16;
						cmd.fin_kind = u2u_pkg::KIND_DECODED;
					end
					cnt_d = 3'd0;
					exp_d = 3'd0;
				end else if (utf8.string_last) begin
					// cut off at string end: flush held bytes, then this one raw
					cmd.flush_n = cnt_q;
					cmd.has_fin = 1'b1;
					cnt_d = 3'd0;
					exp_d = 3'd0;
				end else begin
					hold_wr = 1'b1;
					cnt_d = cnt_q + 3'd1;
					acc_d = nv16;
					ovf_d = novf;
				end
			end else begin
				// broken sequence: flush, then treat this byte afresh
				cmd.flush_n = cnt_q;
				cnt_d = 3'd0;
				exp_d = 3'd0;
			end
		end

		if (fresh) begin
			if (!b[7]) begin
				cmd.has_fin = 1'b1;
				cmd.fin_kind = u2u_pkg::KIND_DECODED;
			end else if (len != 3'd0 && !utf8.string_last) begin
				hold_wr = 1'b1;
				hold_idx = 3'd0;
				cnt_d = 3'd1;
				exp_d = len;
				acc_d = {8'h00, b & u2u_pkg::lead_mask(len)};
				ovf_d = 1'b0;
			end else begin
				cmd.has_fin = 1'b1;
			end
		end

		push = accept && (cmd.has_fin || cmd.flush_n != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			exp_q <= 3'd0;
		end else if (accept) begin
			cnt_q <= cnt_d;
			exp_q <= exp_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q <= acc_d;
			ovf_q <= ovf_d;
			if (hold_wr) begin
				held_q[hold_idx] <= b;
			end
		end
	end

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && utf8.string_last |=> cnt_q == 3'd0)
		else $error("bytes still held after end of string");

	a_cnt_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 3'd0 |-> cnt_q < exp_q && cnt_q <= 3'(u2u_pkg::HELD_MAX))
		else $error("held count not below sequence length");

endmodule

`default_nettype wire

// ===== design/u2u_queue.sv =====
`default_nettype none

module u2u_queue #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [Width-1:0] wr_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  rd_valid,
	output logic [Width-1:0]      rd_data
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	logic [Width-1:0] mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push, do_pop;

	assign full = (count_q == CntW'(Depth));
	assign rd_valid = (count_q != '0);
	assign rd_data = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("queue count beyond depth");

	a_no_lost_push: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

endmodule

`default_nettype wire

// ===== design/u2u_back.sv =====
`default_nettype none

module u2u_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire u2u_pkg::u2u_cmd_t  cmd,
	input  wire logic               cmd_valid,
	output logic                    pop,
	u2u_unit_if.source              ucs2
);

	u2u_pkg::u2u_cmd_t cur_q;
	logic       busy_q;
	logic [2:0] idx_q;
	logic [2:0] total;
	logic       last_unit;
	logic       done;

	assign total = cur_q.flush_n + {2'b00, cur_q.has_fin};
	assign last_unit = (idx_q + 3'd1 == total);
	assign done = busy_q && ucs2.ready && last_unit;
	assign pop = cmd_valid && (!busy_q || done);

	assign ucs2.valid = busy_q;
	assign ucs2.run_last = last_unit;
	assign ucs2.string_end = last_unit && cur_q.last;

	always_comb begin
		if (idx_q < cur_q.flush_n) begin
			ucs2.code_unit = {8'h00, cur_q.held[idx_q]};
			ucs2.unit_kind = u2u_pkg::KIND_RAW;
		end else begin
			ucs2.code_unit = cur_q.fin_unit;
			ucs2.unit_kind = cur_q.fin_kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= 3'd0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q <= 3'd0;
		end else if (done) begin
			busy_q <= 1'b0;
			idx_q <= 3'd0;
		end else if (busy_q && ucs2.ready) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= cmd;
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q < total)
		else $error("unit index past end of work item");

endmodule

`default_nettype wire

// ===== design/utf8_to_ucs2_decoder.sv =====
`default_nettype none

// Path: a byte that yields code units is first written into the queue; the emitter
//   then loads it into its register and raises the output valid once it is free.
// Throughput: one input byte per cycle unless the queue is full; the output side gives one
//   code unit per cycle while ready is high; an item holds the emitter until its 1 to 6 units are out.
// Reset: arst_n clears the held-byte count, the queue pointers and the emitter.
module utf8_to_ucs2_decoder #(
	parameter int unsigned QueueDepth = u2u_pkg::QUEUE_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	u2u_byte_if.sink utf8,
	u2u_unit_if.source ucs2
);

	localparam int unsigned CmdW = $bits(u2u_pkg::u2u_cmd_t);

	u2u_pkg::u2u_cmd_t front_cmd;
	u2u_pkg::u2u_cmd_t back_cmd;
	logic [CmdW-1:0]   q_rd_data;
	logic              push;
	logic              full;
	logic              pop;
	logic              q_valid;

	// Front: classify each byte, keep the partial sequence, queue the units it causes
	u2u_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.utf8   (utf8),
		.full   (full),
		.cmd    (front_cmd),
		.push   (push)
	);

	// Short queue: decouple byte intake from unit emission
	u2u_queue #(
		.Width (CmdW),
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_data  (front_cmd),
		.full     (full),
		.pop      (pop),
		.rd_valid (q_valid),
		.rd_data  (q_rd_data)
	);

	assign back_cmd = u2u_pkg::u2u_cmd_t'(q_rd_data);

	// Back: emit flushed raw bytes first, then the final unit, one per transaction
	u2u_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (back_cmd),
		.cmd_valid (q_valid),
		.pop       (pop),
		.ucs2      (ucs2)
	);

endmodule

`default_nettype wire
